/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define UDEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that is also checked during reset
`define UDEC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/udec_pkg.sv */
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types, constants and decode functions of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

   // depth of the job queue between front and back
   localparam int unsigned QUEUE_DEPTH  = 2;
   // held bytes that are ever read back
   localparam int unsigned HOLD_DEPTH   = 4;
   // bytes a truncated tail hands to the back end
   localparam int unsigned REPLAY_BYTES = 4;
   // longest sequence a lead byte can announce
   localparam logic [2:0]  MAX_SEQ_LEN  = 3'd6;

   // register index of decode_mode
   localparam logic        REG_DECODE_MODE = 1'b0;

   typedef enum logic {
      JOB_SINGLE,
      JOB_REPLAY
   } job_kind_type;

   // one job from front to back
   typedef struct packed {
      job_kind_type                  kind;
      logic [15:0]                   code;
      logic [2:0]                    len;
      logic [8*REPLAY_BYTES-1:0]     rbytes;
      logic [2:0]                    rcount;
   } job_type;

   // decoded unit
   typedef struct packed {
      logic [15:0] code;
      logic [2:0]  len;
   } unit_type;

   // sequence length implied by a lead byte, 0 for an invalid lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80)                      n = 3'd1;
      else if ((b & 8'he0) == 8'hc0)      n = 3'd2;
      else if ((b & 8'hf0) == 8'he0)      n = 3'd3;
      else if ((b & 8'hf8) == 8'hf0)      n = 3'd4;
      else if ((b & 8'hfc) == 8'hf8)      n = 3'd5;
      else if ((b & 8'hfe) == 8'hfc)      n = 3'd6;
      else                                n = 3'd0;
      return n;
   endfunction

   // decode one unit from a three byte window with avail bytes left
   function automatic unit_type parse_unit(input logic [7:0] p0,
                                           input logic [7:0] p1,
                                           input logic [7:0] p2,
                                           input logic [2:0] avail);
      logic [2:0] need;
      unit_type   u;
      need   = lead_length(p0);
      u.code = 16'h0000;
      u.len  = 3'd1;
      if (need == 3'd1) begin
         u.code = {8'h00, p0};
      end else if (need != 3'd0 && avail >= need) begin
         u.len = need;
         if (need == 3'd2) begin
            u.code = {5'b00000, p0[4:0], p1[5:0]};
         end else if (need == 3'd3) begin
            u.code = {p0[3:0], p1[5:0], p2[5:0]};
         end
      end
      return u;
   endfunction

endpackage

/* rtl/core/udec_queue.sv */
// ----------------------------------------------------------------------------
// udec_queue
// Short job queue that decouples the byte classifier from the result engine.
// ----------------------------------------------------------------------------
module udec_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  udec_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output udec_pkg::job_type head_job
);

   localparam int unsigned Depth = udec_pkg::QUEUE_DEPTH;
   localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW  = $clog2(Depth + 1);

   udec_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/udec_front.sv */
// ----------------------------------------------------------------------------
// udec_front
// Accepts text bytes, tracks open sequences and issues result jobs.
// ----------------------------------------------------------------------------
module udec_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              decode_mode,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_text_byte,
   input  logic              req_end_of_text,
   input  logic              q_full,
   output logic              push,
   output udec_pkg::job_type push_job
);

   localparam int unsigned HoldDepth = udec_pkg::HOLD_DEPTH;
   localparam int unsigned HoldW     = $clog2(HoldDepth);
   localparam int unsigned RBytes    = udec_pkg::REPLAY_BYTES;

   logic [2:0]         cnt_ff, cnt_in;
   logic [2:0]         need_ff, need_in;
   logic [7:0]         pend_ff [HoldDepth];
   logic               pend_we;
   logic [HoldW-1:0]   pend_idx;
   logic               accept;
   logic [2:0]         total;
   logic [2:0]         lead;
   logic [7:0]         second;
   udec_pkg::unit_type comp_unit;
   logic [8*RBytes-1:0] rvec;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign total     = cnt_ff + 3'd1;
   assign lead      = udec_pkg::lead_length(req_text_byte);
   assign second    = (cnt_ff == 3'd1) ? req_text_byte : pend_ff[1];
   assign comp_unit = udec_pkg::parse_unit(pend_ff[0], second, req_text_byte, total);

   // bytes after the lead of a truncated sequence, current byte last
   always_comb begin
      rvec = '0;
      for (int i = 0; i < int'(RBytes) - 1; i++) begin
         if (3'(i + 1) < cnt_ff) begin
            rvec[8*i +: 8] = pend_ff[i + 1];
         end else if (3'(i + 1) == cnt_ff) begin
            rvec[8*i +: 8] = req_text_byte;
         end
      end
      if (cnt_ff == 3'(RBytes)) begin
         rvec[8*(RBytes-1) +: 8] = req_text_byte;
      end
   end

   // byte classification and job issue
   always_comb begin
      cnt_in          = cnt_ff;
      need_in         = need_ff;
      push            = 1'b0;
      push_job        = '0;
      push_job.kind   = udec_pkg::JOB_SINGLE;
      push_job.len    = 3'd1;
      pend_we         = 1'b0;
      pend_idx        = '0;
      if (accept) begin
         if (decode_mode) begin
            cnt_in        = 3'd0;
            need_in       = 3'd0;
            push          = 1'b1;
            push_job.code = {8'h00, req_text_byte};
         end else if (cnt_ff == 3'd0) begin
            if (lead == 3'd1) begin
               push          = 1'b1;
               push_job.code = {8'h00, req_text_byte};
            end else if (lead == 3'd0 || req_end_of_text) begin
               push          = 1'b1;
            end else begin
               pend_we  = 1'b1;
               cnt_in   = 3'd1;
               need_in  = lead;
            end
         end else if (total >= need_ff) begin
            push          = 1'b1;
            push_job.code = comp_unit.code;
            push_job.len  = total;
            cnt_in        = 3'd0;
            need_in       = 3'd0;
         end else if (req_end_of_text) begin
            push            = 1'b1;
            push_job.kind   = udec_pkg::JOB_REPLAY;
            push_job.rbytes = rvec;
            push_job.rcount = cnt_ff;
            cnt_in          = 3'd0;
            need_in         = 3'd0;
         end else if (cnt_ff < udec_pkg::MAX_SEQ_LEN - 3'd1) begin
            if (cnt_ff < 3'(HoldDepth)) begin
               pend_we  = 1'b1;
               pend_idx = cnt_ff[HoldW-1:0];
            end
            cnt_in = total;
         end else begin
            cnt_in  = 3'd0;
            need_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         need_ff <= 3'd0;
      end else begin
         cnt_ff  <= cnt_in;
         need_ff <= need_in;
      end
   end

   // held sequence bytes
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_ff[pend_idx] <= req_text_byte;
      end
   end

endmodule

/* rtl/core/udec_back.sv */
// ----------------------------------------------------------------------------
// udec_back
// Turns jobs into result transfers and replays truncated tails unit by unit.
// ----------------------------------------------------------------------------
module udec_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  udec_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_code_unit,
   output logic [2:0]        rsp_seq_length,
   output logic              rsp_last_result
);

   localparam int unsigned RBytes = udec_pkg::REPLAY_BYTES;

   typedef enum logic {
      BK_IDLE,
      BK_REPLAY
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic                valid_ff, valid_in;
   logic [15:0]         code_ff, code_in;
   logic [2:0]          len_ff, len_in;
   logic                last_ff, last_in;
   logic [8*RBytes-1:0] rbuf_ff, rbuf_in;
   logic [2:0]          rem_ff, rem_in;
   logic                out_free;
   udec_pkg::unit_type  pu;

   assign out_free        = !valid_ff || rsp_ready;
   assign pu              = udec_pkg::parse_unit(rbuf_ff[7:0], rbuf_ff[15:8],
                                                 rbuf_ff[23:16], rem_ff);
   assign rsp_valid       = valid_ff;
   assign rsp_code_unit   = code_ff;
   assign rsp_seq_length  = len_ff;
   assign rsp_last_result = last_ff;

   // result sequencing
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      code_in  = code_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      rbuf_in  = rbuf_ff;
      rem_in   = rem_ff;
      pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (out_free) begin
               valid_in = head_valid;
               if (head_valid) begin
                  pop = 1'b1;
                  if (head_job.kind == udec_pkg::JOB_SINGLE) begin
                     code_in = head_job.code;
                     len_in  = head_job.len;
                     last_in = 1'b1;
                  end else begin
                     // lead of the cut sequence, then replay the rest
                     code_in  = 16'h0000;
                     len_in   = 3'd1;
                     last_in  = 1'b0;
                     rbuf_in  = head_job.rbytes;
                     rem_in   = head_job.rcount;
                     state_in = BK_REPLAY;
                  end
               end
            end
         end
         BK_REPLAY: begin
            if (out_free) begin
               valid_in = 1'b1;
               code_in  = pu.code;
               len_in   = pu.len;
               rem_in   = rem_ff - pu.len;
               last_in  = (rem_in == 3'd0);
               rbuf_in  = rbuf_ff >> {pu.len, 3'b000};
               if (rem_in == 3'd0) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      len_ff  <= len_in;
      last_ff <= last_in;
      rbuf_ff <= rbuf_in;
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         rem_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

/* rtl/core/utf8_to_ucs2_stream_decoder_top.sv */
// A byte's job is stored in the job queue; its result is then registered by the back end.
// Throughput: one byte per cycle; the front takes a byte whenever the job queue has room.
// A truncated tail gives one result per cycle from the replay loop unless stalled (up to 5).
// Reset: synchronous, active high; clears decode_mode, open sequence, queue and rsp_valid.
// Held sequence bytes are not cleared; they are always written before being read.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_top
// Streaming UTF-8 to UCS-2 decoder with an APB-style control register.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [2:0]  rsp_seq_length,
   output logic        rsp_last_result,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic              mode_ff, mode_in;
   logic              csr_wr;
   logic              q_full, push, pop, head_valid;
   udec_pkg::job_type push_job, head_job;

   // control register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mode_in    = (csr_wr && csr_paddr[2] == udec_pkg::REG_DECODE_MODE) ?
                       csr_pwdata[0] : mode_ff;
   assign csr_prdata = (csr_paddr[2] == udec_pkg::REG_DECODE_MODE) ?
                       {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   udec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .decode_mode     (mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .push            (push),
      .push_job        (push_job)
   );

   udec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   udec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_seq_length  (rsp_seq_length),
      .rsp_last_result (rsp_last_result)
   );

endmodule

/* rtl/core/udec_checker.sv */
// ----------------------------------------------------------------------------
// udec_checker
// Port-level checks of the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic [2:0]  rsp_seq_length,
   input logic        rsp_last_result
);

   // stalled result holds
   `UDEC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit) && $stable(rsp_seq_length) && $stable(rsp_last_result), "result changed while stalled")

   // consumed length is always 1 to 6
   `UDEC_ASSERT(a_len_range, clock, reset, rsp_valid |-> rsp_seq_length != 3'd0 && rsp_seq_length != 3'd7, "sequence length out of range")

   // single byte units never exceed one byte of value
   `UDEC_ASSERT(a_len1_byte, clock, reset, rsp_valid && rsp_seq_length == 3'd1 |-> rsp_code_unit[15:8] == 8'h00, "single byte unit above 0xff")

   // four to six byte sequences are unrepresentable
   `UDEC_ASSERT(a_long_zero, clock, reset, rsp_valid && rsp_seq_length[2] |-> rsp_code_unit == 16'h0000, "long sequence gave a nonzero unit")

   // no result right after reset
   `UDEC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_valid, "result valid after reset")

endmodule

bind utf8_to_ucs2_stream_decoder_top udec_checker u_udec_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_code_unit   (rsp_code_unit),
   .rsp_seq_length  (rsp_seq_length),
   .rsp_last_result (rsp_last_result)
);
